/* rtl/core/plss_pkg.sv */
// plss_pkg: shared codes, defaults and types for the positional list shift store
// no dependencies; imported by plss_cell and positional_list_shift_store
`default_nettype none

package plss_pkg;

  localparam int unsigned DefCapacity   = 64;
  localparam int unsigned DefValueWidth = 16;

  localparam int unsigned OpW     = 3;
  localparam int unsigned InValW  = 16;
  localparam int unsigned PosW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutCntW = 7;

  localparam logic [OpW-1:0] OpInsFront = 3'd0;
  localparam logic [OpW-1:0] OpInsBack  = 3'd1;
  localparam logic [OpW-1:0] OpInsAt    = 3'd2;
  localparam logic [OpW-1:0] OpRemFront = 3'd3;
  localparam logic [OpW-1:0] OpRemBack  = 3'd4;
  localparam logic [OpW-1:0] OpRemAt    = 3'd5;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;
  localparam logic [StatusW-1:0] StRange = 2'd3;

  typedef struct packed {
    logic ins;
    logic rem;
  } plss_shift_t;

endpackage

`default_nettype wire

/* rtl/core/plss_cell.sv */
// plss_cell: one list slot; loads a new entry or takes its left or right neighbor
// depends on plss_pkg
`default_nettype none

module plss_cell #(
  parameter int unsigned VALUE_WIDTH = plss_pkg::DefValueWidth,
  parameter int unsigned CNT_W       = 7,
  parameter int unsigned IDX         = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire plss_pkg::plss_shift_t  shift_i,
  input  wire logic [CNT_W-1:0]       at_i,
  input  wire logic [VALUE_WIDTH-1:0] ins_val_i,
  input  wire logic [VALUE_WIDTH-1:0] left_i,
  input  wire logic [VALUE_WIDTH-1:0] right_i,
  output logic      [VALUE_WIDTH-1:0] val_o,
  output logic      [VALUE_WIDTH-1:0] sel_o
);
  import plss_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [VALUE_WIDTH-1:0] val_d, val_q;
  logic                   hit, above;

  assign hit   = (at_i == MyIdx);
  assign above = (MyIdx > at_i);

  always_comb begin
    val_d = val_q;
    if (shift_i.ins) begin
      if (hit) begin
        val_d = ins_val_i;
      end else if (above) begin
        val_d = left_i;
      end
    end else if (shift_i.rem) begin
      if (hit || above) begin
        val_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign sel_o = hit ? val_q : '0;

endmodule

`default_nettype wire

/* rtl/core/positional_list_shift_store.sv */
// positional_list_shift_store: ordered list kept in a row of shifting cells
// channels in, one result per request out through a registered output stage
// on a request the cells insert at the front, back or a position (later entries
// move up one cell) or remove (later entries move down one cell)
// request on the slave side: opcode, entry value, position
// result on the master side: removed value, status, entry count after the step
// the result is registered and becomes valid in the cycle after the request is accepted
// throughput: one request per cycle unless the receiver stalls, set by the one-deep
// output register
// a full list rejects inserts, an empty list rejects removes, a bad position is
// rejected; a rejected request changes nothing and reports its status
// reset clears the count and the output valid flag; cell contents are undefined
// until written and never read before that
// when the receiver stalls, the held result stays and no new request is taken
// depends on plss_pkg, plss_cell
`default_nettype none

module positional_list_shift_store #(
  parameter int unsigned CAPACITY    = plss_pkg::DefCapacity,
  parameter int unsigned VALUE_WIDTH = plss_pkg::DefValueWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [2:0] opcode, [18:3] entry_value, [25:19] position, [31:26] zero
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [15:0] removed_value, [17:16] status, [24:18] entry_count, [31:25] zero
  output logic      [31:0] m_axis_tdata_o
);
  import plss_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned ExtW = (VALUE_WIDTH > InValW) ? VALUE_WIDTH : InValW;
  localparam logic [CntW-1:0] CapVal = CntW'(CAPACITY);

  logic [OpW-1:0]    op;
  logic [InValW-1:0] in_val;
  logic [PosW-1:0]   pos;
  logic              accept;

  logic [CntW-1:0] count_d, count_q;
  logic [CmpW-1:0] cnt_ext, pos_ext, at_ext;
  logic [CntW-1:0] at;
  logic [StatusW-1:0] status;
  plss_shift_t shift;

  logic [ExtW-1:0]        in_ext, rem_ext;
  logic [VALUE_WIDTH-1:0] ins_val;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_sel [CAPACITY];
  logic [VALUE_WIDTH-1:0] sel_or;
  logic [InValW-1:0]      removed;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  assign op     = s_axis_tdata_i[OpW-1:0];
  assign in_val = s_axis_tdata_i[OpW+InValW-1:OpW];
  assign pos    = s_axis_tdata_i[OpW+InValW+PosW-1:OpW+InValW];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign cnt_ext = CmpW'(count_q);
  assign pos_ext = CmpW'(pos);

  always_comb begin
    shift   = '0;
    status  = StOk;
    at_ext  = '0;
    count_d = count_q;
    unique case (op)
      OpInsFront, OpInsBack, OpInsAt: begin
        if (op == OpInsBack) begin
          at_ext = cnt_ext;
        end else if (op == OpInsAt) begin
          at_ext = pos_ext;
        end
        if (count_q >= CapVal) begin
          status = StFull;
        end else if (at_ext > cnt_ext) begin
          status = StRange;
        end else begin
          shift.ins = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OpRemFront, OpRemBack, OpRemAt: begin
        if (op == OpRemBack) begin
          at_ext = cnt_ext - 1'b1;
        end else if (op == OpRemAt) begin
          at_ext = pos_ext;
        end
        if (count_q == '0) begin
          status = StEmpty;
        end else if (at_ext >= cnt_ext) begin
          status = StRange;
        end else begin
          shift.rem = 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      default: begin
        status = StOk;
      end
    endcase
  end

  assign at      = at_ext[CntW-1:0];
  assign in_ext  = ExtW'(in_val);
  assign ins_val = in_ext[VALUE_WIDTH-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plss_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W      (CntW),
      .IDX        (i)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .shift_i  (shift),
      .at_i     (at),
      .ins_val_i(ins_val),
      .left_i   ((i == 0) ? '0 : cell_val[(i == 0) ? 0 : i - 1]),
      .right_i  ((i == CAPACITY - 1) ? '0 : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .val_o    (cell_val[i]),
      .sel_o    (cell_sel[i])
    );
  end

  always_comb begin
    sel_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_or = sel_or | cell_sel[i];
    end
  end

  assign rem_ext = ExtW'(sel_or);
  assign removed = shift.rem ? rem_ext[InValW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {7'd0, OutCntW'(count_d), status, removed};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire
